[rtl/core/ensc_pkg.sv]
package ensc_pkg;

    typedef enum logic [1:0]
    {
        OP_TEMP = 2'd0,
        OP_PRES = 2'd1,
        OP_HUM  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DIVW = 2'd2
    } state_t;

    localparam int STEP_W = 4;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;
    localparam int DIV_W  = 32;

    localparam logic [31:0] K_P_OFFSET  = 32'd64000;
    localparam logic [31:0] K_P_BASE    = 32'd1048576;
    localparam logic [31:0] K_P_SCALE   = 32'd3125;
    localparam logic [31:0] K_P_ONE     = 32'd32768;
    localparam logic [31:0] K_H_OFFSET  = 32'd76800;
    localparam logic [31:0] K_H_MAX     = 32'd419430400;
    localparam logic [31:0] K_H_BIAS    = 32'd2097152;
    localparam logic [31:0] K_H_ROUND_A = 32'd16384;
    localparam logic [31:0] K_H_ONE     = 32'd32768;
    localparam logic [31:0] K_H_ROUND_B = 32'd8192;

    // Controller to datapath commands.
    typedef struct packed
    {
        logic                load;
        logic                step_en;
        logic [STEP_W-1:0]   step;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed
    {
        logic last;
        logic div_step;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // Arithmetic shift right of a 32-bit two's complement word.
    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

[rtl/core/ensc_in_if.sv]
interface ensc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [23:0] raw_burst;

    modport source (output valid, output opcode, output raw_burst, input ready);
    modport sink   (input valid, input opcode, input raw_burst, output ready);
endinterface

[rtl/core/ensc_out_if.sv]
interface ensc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [32:0] value;
    logic               zero_divisor;

    modport source (output valid, output kind, output value, output zero_divisor,
                    input ready);
    modport sink   (input valid, input kind, input value, input zero_divisor,
                    output ready);
endinterface

[rtl/core/env_sensor_compensation.sv]
// Compensates raw temperature, pressure and humidity samples with the
// 32-bit integer scheme, using calibration bytes written to four 64-bit
// trim registers. One request is handled at a time through a single shared
// 32x32 multiplier, one step per cycle while the controller is not waiting
// on the divider or on a full output register; pressure waits for the
// bit-serial 32-bit divider unless its divisor is zero. A finished result
// waits in an output register, and the next request is accepted while it
// waits. Temperature requests update the stored fine temperature used by
// later pressure and humidity requests.
module env_sensor_compensation
(
    input  logic                        clk,
    input  logic                        rst_n,
    ensc_in_if.sink                     in_ch,
    ensc_out_if.source                  out_ch,
    input  logic                        cfg_we,
    input  logic [ensc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ensc_pkg::CFG_W-1:0]  cfg_data
);
    import ensc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ensc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ensc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (in_ch.opcode),
        .in_raw    (in_ch.raw_burst),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_kind  (out_ch.kind),
        .out_value (out_ch.value),
        .out_zero  (out_ch.zero_divisor)
    );
endmodule

[rtl/core/ensc_div.sv]
module ensc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ensc_pkg::DIV_W-1:0]  dividend,
    input  logic [ensc_pkg::DIV_W-1:0]  divisor,
    output logic [ensc_pkg::DIV_W-1:0]  quotient,
    output logic                        done
);
    import ensc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     shifted;

    // One restoring step per cycle, quotient bits shift in from the right.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

[rtl/core/ensc_dp.sv]
module ensc_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ensc_pkg::dp_cmd_t           cmd,
    output ensc_pkg::dp_stat_t          stat,
    input  logic                        cfg_we,
    input  logic [ensc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ensc_pkg::CFG_W-1:0]  cfg_data,
    input  logic [1:0]                  in_opcode,
    input  logic [23:0]                 in_raw,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_kind,
    output logic signed [32:0]          out_value,
    output logic                        out_zero
);
    import ensc_pkg::*;

    logic [CFG_W-1:0] trim_reg [4];
    logic [7:0]       tbyte [32];

    logic [1:0]  op_reg;
    logic [23:0] raw_reg;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0] d_reg, d_next, e_reg, e_next, ft_reg, ft_next;
    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic [32:0] val_reg;
    logic        zd_reg;

    logic [31:0] x, y, m, tmp, res32;
    logic [32:0] res;
    logic        last, div_step, div_go, zflag;
    logic [31:0] dvd, quo;
    logic        div_done;

    logic [31:0] adc_tp, adc_h;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    // Calibration byte unpacking.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            tbyte[i] = trim_reg[i / 8][8 * (i % 8) +: 8];
        end
    end

    assign t1 = {16'd0, tbyte[1], tbyte[0]};
    assign t2 = 32'($signed({tbyte[3], tbyte[2]}));
    assign t3 = 32'($signed({tbyte[5], tbyte[4]}));
    assign p1 = {16'd0, tbyte[7], tbyte[6]};
    assign p2 = 32'($signed({tbyte[9], tbyte[8]}));
    assign p3 = 32'($signed({tbyte[11], tbyte[10]}));
    assign p4 = 32'($signed({tbyte[13], tbyte[12]}));
    assign p5 = 32'($signed({tbyte[15], tbyte[14]}));
    assign p6 = 32'($signed({tbyte[17], tbyte[16]}));
    assign p7 = 32'($signed({tbyte[19], tbyte[18]}));
    assign p8 = 32'($signed({tbyte[21], tbyte[20]}));
    assign p9 = 32'($signed({tbyte[23], tbyte[22]}));
    assign h1 = {24'd0, tbyte[24]};
    assign h2 = 32'($signed({tbyte[26], tbyte[25]}));
    assign h3 = {24'd0, tbyte[27]};
    assign h4 = 32'($signed({tbyte[28], tbyte[29][3:0]}));
    assign h5 = 32'($signed({tbyte[30], tbyte[29][7:4]}));
    assign h6 = 32'($signed(tbyte[31]));

    assign adc_tp = {12'd0, raw_reg[23:4]};
    assign adc_h  = {16'd0, raw_reg[23:8]};

    // The one shared multiplier, low 32 bits of the product.
    assign m = x * y;

    // Per-step operand select and register updates.
    always_comb
    begin
        x        = '0;
        y        = '0;
        tmp      = '0;
        res32    = '0;
        res      = '0;
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        ft_next  = ft_reg;
        last     = 1'b0;
        div_step = 1'b0;
        div_go   = 1'b0;
        zflag    = 1'b0;
        dvd      = b_reg[31] ? b_reg : {b_reg[30:0], 1'b0};
        case (op_t'(op_reg))
            OP_TEMP:
            begin
                case (cmd.step)
                    4'd0:
                    begin
                        x = (adc_tp >> 3) - (t1 << 1);
                        y = t2;
                        a_next = m;
                    end
                    4'd1:
                    begin
                        x = (adc_tp >> 4) - t1;
                        y = x;
                        b_next = m;
                    end
                    4'd2:
                    begin
                        x = asr(b_reg, 12);
                        y = t3;
                        b_next = m;
                    end
                    4'd3:
                    begin
                        tmp = asr(a_reg, 11) + asr(b_reg, 14);
                        x = tmp;
                        y = 32'd5;
                        ft_next = tmp;
                        c_next = m;
                    end
                    default:
                    begin
                        last = 1'b1;
                        res32 = asr(c_reg + 32'd128, 8);
                        res = {res32[31], res32};
                    end
                endcase
            end
            OP_PRES:
            begin
                case (cmd.step)
                    4'd0:
                    begin
                        tmp = asr(ft_reg, 1) - K_P_OFFSET;
                        a_next = tmp;
                        x = asr(tmp, 2);
                        y = x;
                        b_next = m;
                    end
                    4'd1:
                    begin
                        x = asr(b_reg, 11);
                        y = p6;
                        c_next = m;
                    end
                    4'd2:
                    begin
                        x = a_reg;
                        y = p5;
                        c_next = c_reg + (m << 1);
                    end
                    4'd3:
                    begin
                        c_next = asr(c_reg, 2) + (p4 << 16);
                        x = p3;
                        y = asr(b_reg, 13);
                        d_next = m;
                    end
                    4'd4:
                    begin
                        x = p2;
                        y = a_reg;
                        e_next = m;
                    end
                    4'd5:
                    begin
                        tmp = asr(asr(d_reg, 3) + asr(e_reg, 1), 18);
                        x = K_P_ONE + tmp;
                        y = p1;
                        a_next = m;
                    end
                    4'd6:
                    begin
                        tmp = asr(a_reg, 15);
                        if (tmp == 32'd0)
                        begin
                            // Zero divisor: report zero with the flag.
                            last = 1'b1;
                            zflag = 1'b1;
                        end
                        else
                        begin
                            a_next = tmp;
                            x = (K_P_BASE - adc_tp) - asr(c_reg, 12);
                            y = K_P_SCALE;
                            b_next = m;
                        end
                    end
                    4'd7:
                    begin
                        div_step = 1'b1;
                        div_go = 1'b1;
                    end
                    4'd8:
                    begin
                        tmp = b_reg[31] ? {quo[30:0], 1'b0} : quo;
                        b_next = tmp;
                        x = tmp >> 3;
                        y = x;
                        d_next = m;
                    end
                    4'd9:
                    begin
                        x = p9;
                        y = d_reg >> 13;
                        d_next = m;
                    end
                    4'd10:
                    begin
                        x = b_reg >> 2;
                        y = p8;
                        e_next = m;
                    end
                    default:
                    begin
                        last = 1'b1;
                        res32 = b_reg + asr(asr(d_reg, 12) + asr(e_reg, 13) + p7, 4);
                        res = {1'b0, res32};
                    end
                endcase
            end
            OP_HUM:
            begin
                case (cmd.step)
                    4'd0:
                    begin
                        tmp = ft_reg - K_H_OFFSET;
                        a_next = tmp;
                        x = h5;
                        y = tmp;
                        b_next = m;
                    end
                    4'd1:
                    begin
                        c_next = asr((adc_h << 14) - (h4 << 20) - b_reg + K_H_ROUND_A, 15);
                        x = a_reg;
                        y = h6;
                        b_next = m;
                    end
                    4'd2:
                    begin
                        x = a_reg;
                        y = h3;
                        d_next = m;
                    end
                    4'd3:
                    begin
                        x = asr(b_reg, 10);
                        y = asr(d_reg, 11) + K_H_ONE;
                        b_next = m;
                    end
                    4'd4:
                    begin
                        x = asr(b_reg, 10) + K_H_BIAS;
                        y = h2;
                        b_next = m;
                    end
                    4'd5:
                    begin
                        x = c_reg;
                        y = asr(b_reg + K_H_ROUND_B, 14);
                        d_next = m;
                    end
                    4'd6:
                    begin
                        x = asr(d_reg, 15);
                        y = x;
                        e_next = m;
                    end
                    4'd7:
                    begin
                        x = asr(e_reg, 7);
                        y = h1;
                        e_next = m;
                    end
                    default:
                    begin
                        // Clamp to the valid humidity range before scaling.
                        last = 1'b1;
                        tmp = d_reg - asr(e_reg, 4);
                        if (tmp[31])
                        begin
                            tmp = '0;
                        end
                        else if (tmp > K_H_MAX)
                        begin
                            tmp = K_H_MAX;
                        end
                        res = {13'd0, tmp[31:12]};
                    end
                endcase
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    ensc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go && cmd.step_en),
        .dividend (dvd),
        .divisor  (a_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // Configuration and fine-temperature state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                trim_reg[i] <= '0;
            end
            ft_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                trim_reg[cfg_index] <= cfg_data;
            end
            if (cmd.step_en)
            begin
                ft_reg <= ft_next;
            end
            if (cmd.step_en && last)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            raw_reg <= in_raw;
        end
        if (cmd.step_en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
        if (cmd.step_en && last)
        begin
            kind_reg <= op_reg;
            val_reg  <= res;
            zd_reg   <= zflag;
        end
    end

    assign stat.last     = last;
    assign stat.div_step = div_step;
    assign stat.div_done = div_done;
    assign stat.out_free = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_kind  = kind_reg;
    assign out_value = $signed(val_reg);
    assign out_zero  = zd_reg;
endmodule

[rtl/core/ensc_ctrl.sv]
module ensc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output ensc_pkg::dp_cmd_t   cmd,
    input  ensc_pkg::dp_stat_t  stat
);
    import ensc_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Step sequencing: one datapath step per cycle, holding for the divider and, on the last step, for a free output.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.step_en = 1'b0;
        cmd.step    = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.last || stat.out_free)
                begin
                    cmd.step_en = 1'b1;
                    step_next   = step_reg + 1'b1;
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.div_step)
                    begin
                        state_next = ST_DIVW;
                    end
                end
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/core/ensc_chk.sv]
module ensc_chk
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         out_kind,
    input  logic signed [32:0] out_value,
    input  logic               out_zero
);
    import ensc_pkg::*;

    // A pending result stays until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // Only pressure can report a zero divisor, and then with value zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_zero |-> out_kind == OP_PRES && out_value == 33'sd0)
        else $error("zero divisor flag on a bad result");

    // Humidity stays within the clamped range.
    a_hum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OP_HUM |-> out_value >= 33'sd0 && out_value <= 33'sd102400)
        else $error("humidity out of range");

    // Temperature is sign-extended from 32 bits.
    a_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OP_TEMP |-> out_value[32] == out_value[31])
        else $error("temperature not sign-extended");
endmodule

bind env_sensor_compensation ensc_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_value (out_ch.value),
    .out_zero  (out_ch.zero_divisor)
);
